@@ rtl/core/tscd_pkg.sv @@
// ----------------------------------------------------------------------------
// tscd_pkg
// Types, register indexes and saturating arithmetic of the two-sided CUSUM
// change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tscd_pkg;

  localparam int SMP_W     = 16;
  localparam int MAG_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int THR_W     = 40;
  localparam int SUM_W     = 48;
  localparam int SUM_XW    = SUM_W + 1;
  localparam int OUT_IDX_W = 12;
  localparam int DIFF_W    = SMP_W + 3;
  localparam int PROD_W    = 36;
  localparam int INC_W     = 34;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_LEVEL       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_MAGNITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN             = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD        = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    restart;
  } in_item_t;

  typedef struct packed {
    logic                 alarm;
    logic                 direction;
    logic [OUT_IDX_W-1:0] detect_index;
    logic [OUT_IDX_W-1:0] change_index;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [THR_W-1:0]     wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] mean_level;
    logic [MAG_W-1:0]        change_magnitude;
    logic [GAIN_W-1:0]       gain;
    logic [THR_W-1:0]        threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [INC_W-1:0] inc_up;
    logic signed [INC_W-1:0] inc_down;
    logic                    restart;
  } incr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [INC_W-1:0] b
  );
    logic signed [SUM_XW-1:0] s;
    s = SUM_XW'(a) + SUM_XW'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tscd_stream_if.sv @@
// ----------------------------------------------------------------------------
// tscd_stream_if
// Valid/ready channel carrying one payload of a given type per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tscd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/two_sided_cusum_detector_unit.sv @@
// ----------------------------------------------------------------------------
// two_sided_cusum_detector_unit
// Two-sided CUSUM change detector with one result transaction per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed sample per transaction, with a restart flag that
//            opens a new series at index 0.
//   out_ch : one result per sample: alarm, direction, detect and change index.
//   cfg_ch : register writes (mean level, change magnitude, gain, threshold),
//            always ready; write only while no transaction is in flight.
//   Path: a sample enters the queue, is popped by the back end and its
//   result is registered for out_ch. Throughput: one sample per cycle while
//   out_ch does not stall, set by the back end's sum/minimum/threshold update.
//   The front forms both gain products; a short queue sits between front
//   and back, and a result register sits at the output, so in_ch keeps
//   accepting while a result waits. When out_ch stalls, the queue fills and
//   in_ch.ready drops once it is full.
//   Reset (rst_n low, synchronous): registers go to their reset values,
//   the series state clears and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module two_sided_cusum_detector_unit #(
  parameter int MAX_SAMPLES = 4096,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  tscd_stream_if.sink   in_ch,
  tscd_stream_if.source out_ch,
  tscd_stream_if.sink   cfg_ch
);
  import tscd_pkg::*;

  cfg_regs_t cfg_r;
  in_item_t  in_item;
  cfg_item_t cfg_item;
  out_item_t out_item;
  incr_t     push_item, pop_item;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  q_stat_t   q_stat;

  assign in_item      = in_ch.payload;
  assign cfg_item     = cfg_ch.payload;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.payload = out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_level       <= '0;
      cfg_r.change_magnitude <= '0;
      cfg_r.gain             <= GAIN_RESET;
      cfg_r.threshold        <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_item.reg_index)
        REG_MEAN_LEVEL:       cfg_r.mean_level       <= cfg_item.wr_data[SMP_W-1:0];
        REG_CHANGE_MAGNITUDE: cfg_r.change_magnitude <= cfg_item.wr_data[MAG_W-1:0];
        REG_GAIN:             cfg_r.gain             <= cfg_item.wr_data[GAIN_W-1:0];
        REG_THRESHOLD:        cfg_r.threshold        <= cfg_item.wr_data;
        default: begin
        end
      endcase
    end
  end

  tscd_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tscd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .stat       (q_stat)
  );

  tscd_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .threshold (cfg_r.threshold),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  a_no_result_after_reset: assert property (
    @(posedge clk) !rst_n |=> !out_ch.valid
  ) else $error("result pending right after reset");

  a_stall_only_when_queued: assert property (
    @(posedge clk) disable iff (!rst_n) !in_ch.ready |-> !q_stat.empty
  ) else $error("input stalled with an empty queue");

  a_quiet_fields_without_alarm: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.payload.alarm |->
      !out_ch.payload.direction && out_ch.payload.detect_index == '0 &&
      out_ch.payload.change_index == '0
  ) else $error("result fields set without an alarm");

endmodule

`default_nettype wire

@@ rtl/core/tscd_front.sv @@
// ----------------------------------------------------------------------------
// tscd_front
// Input side: centers the sample and forms both scaled log-likelihood
// increments, then pushes them with the restart flag into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  tscd_pkg::in_item_t  in_item,
  input  tscd_pkg::cfg_regs_t cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output tscd_pkg::incr_t     push_item
);
  import tscd_pkg::*;

  logic signed [DIFF_W-1:0] centered;
  logic signed [DIFF_W-1:0] twice;
  logic signed [DIFF_W-1:0] mag;
  logic signed [DIFF_W-1:0] arg_up;
  logic signed [DIFF_W-1:0] arg_down;
  logic signed [PROD_W-1:0] gain_ext;
  logic signed [PROD_W-1:0] prod_up;
  logic signed [PROD_W-1:0] prod_down;

  always_comb begin
    centered  = DIFF_W'(in_item.sample) - DIFF_W'(cfg.mean_level);
    twice     = centered <<< 1;
    mag       = DIFF_W'($signed({1'b0, cfg.change_magnitude}));
    arg_up    = twice - mag;
    arg_down  = DIFF_W'(0) - twice - mag;
    gain_ext  = PROD_W'($signed({1'b0, cfg.gain}));
    prod_up   = PROD_W'(arg_up) * gain_ext;
    prod_down = PROD_W'(arg_down) * gain_ext;
  end

  // floor of half: drop the low bit of the arithmetic product
  assign push_item.inc_up   = prod_up[INC_W:1];
  assign push_item.inc_down = prod_down[INC_W:1];
  assign push_item.restart  = in_item.restart;
  assign push_valid         = in_valid;
  assign in_ready           = push_ready;

endmodule

`default_nettype wire

@@ rtl/core/tscd_fifo.sv @@
// ----------------------------------------------------------------------------
// tscd_fifo
// Short register queue of increment transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  tscd_pkg::incr_t   push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tscd_pkg::incr_t   pop_item,
  output tscd_pkg::q_stat_t stat
);
  import tscd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  incr_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_fire;
  logic          pop_fire;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tscd_back.sv @@
// ----------------------------------------------------------------------------
// tscd_back
// Series state: saturating sums, running minima, alarm test and freeze,
// and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_back #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tscd_pkg::incr_t              pop_item,
  input  logic [tscd_pkg::THR_W-1:0]   threshold,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tscd_pkg::out_item_t          out_item
);
  import tscd_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  logic signed [SUM_W-1:0] sum_up_r, sum_up_nxt, sum_dn_r, sum_dn_nxt;
  logic signed [SUM_W-1:0] min_up_r, min_up_nxt, min_dn_r, min_dn_nxt;
  logic [IDX_W-1:0]        arg_up_r, arg_up_nxt, arg_dn_r, arg_dn_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        det_r, det_nxt, chg_r, chg_nxt;
  logic                    alarm_r, alarm_nxt, dir_r, dir_nxt;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic                    pop_fire;
  logic                    frozen;
  logic signed [SUM_W-1:0] base_sum_up, base_sum_dn, base_min_up, base_min_dn;
  logic [IDX_W-1:0]        base_arg_up, base_arg_dn, n;
  logic signed [SUM_W-1:0] new_up, new_dn;
  logic [SUM_W-1:0]        gap_up, gap_dn, thr_ext;
  logic                    first, take_up, take_dn, hit_up, hit_dn;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;
  assign frozen    = alarm_r && !pop_item.restart;
  assign thr_ext   = SUM_W'(threshold);

  always_comb begin
    base_sum_up = pop_item.restart ? '0 : sum_up_r;
    base_sum_dn = pop_item.restart ? '0 : sum_dn_r;
    base_min_up = pop_item.restart ? '0 : min_up_r;
    base_min_dn = pop_item.restart ? '0 : min_dn_r;
    base_arg_up = pop_item.restart ? '0 : arg_up_r;
    base_arg_dn = pop_item.restart ? '0 : arg_dn_r;
    n           = pop_item.restart ? '0 : idx_r;
    first       = (n == '0);
    new_up      = sat_add(base_sum_up, pop_item.inc_up);
    new_dn      = sat_add(base_sum_dn, pop_item.inc_down);
    take_up     = first || (new_up < base_min_up);
    take_dn     = first || (new_dn < base_min_dn);
    gap_up      = new_up - base_min_up;
    gap_dn      = new_dn - base_min_dn;
    hit_up      = !take_up && (gap_up > thr_ext);
    hit_dn      = !take_dn && (gap_dn > thr_ext);

    sum_up_nxt = sum_up_r;
    sum_dn_nxt = sum_dn_r;
    min_up_nxt = min_up_r;
    min_dn_nxt = min_dn_r;
    arg_up_nxt = arg_up_r;
    arg_dn_nxt = arg_dn_r;
    idx_nxt    = idx_r;
    alarm_nxt  = alarm_r;
    dir_nxt    = dir_r;
    det_nxt    = det_r;
    chg_nxt    = chg_r;
    if (pop_fire && !frozen) begin
      sum_up_nxt = new_up;
      sum_dn_nxt = new_dn;
      min_up_nxt = take_up ? new_up : base_min_up;
      min_dn_nxt = take_dn ? new_dn : base_min_dn;
      arg_up_nxt = take_up ? n : base_arg_up;
      arg_dn_nxt = take_dn ? n : base_arg_dn;
      alarm_nxt  = hit_up || hit_dn;
      dir_nxt    = !hit_up && hit_dn;
      det_nxt    = (hit_up || hit_dn) ? n : '0;
      chg_nxt    = hit_up ? arg_up_nxt : (hit_dn ? arg_dn_nxt : '0);
      idx_nxt    = (!(hit_up || hit_dn) && (n < IDX_LAST)) ? n + 1'b1 : n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_up_r    <= '0;
      sum_dn_r    <= '0;
      min_up_r    <= '0;
      min_dn_r    <= '0;
      arg_up_r    <= '0;
      arg_dn_r    <= '0;
      idx_r       <= '0;
      alarm_r     <= 1'b0;
      dir_r       <= 1'b0;
      det_r       <= '0;
      chg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_up_r <= sum_up_nxt;
      sum_dn_r <= sum_dn_nxt;
      min_up_r <= min_up_nxt;
      min_dn_r <= min_dn_nxt;
      arg_up_r <= arg_up_nxt;
      arg_dn_r <= arg_dn_nxt;
      idx_r    <= idx_nxt;
      alarm_r  <= alarm_nxt;
      dir_r    <= dir_nxt;
      det_r    <= det_nxt;
      chg_r    <= chg_nxt;
      if (pop_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      out_item_r.alarm        <= alarm_nxt;
      out_item_r.direction    <= dir_nxt;
      out_item_r.detect_index <= OUT_IDX_W'(det_nxt);
      out_item_r.change_index <= OUT_IDX_W'(chg_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-sided CUSUM change detector. A short table
// of directed rows comes first, some with hand-computed results. Random
// sample series follow under extreme and random register settings, then a
// steep run that drives the upward sum far below zero, rising samples after
// it, and a final stretch without stalls. Every result transaction is
// checked field by field against a local model or a hand-computed result.
// ----------------------------------------------------------------------------
module tb_top;
  import tscd_pkg::*;

  localparam int SERIES_CAP  = 4096;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_ITEMS = 100;
  localparam logic [THR_W-1:0] THR_ALL = '1;
  localparam int NUM_ROWS = 14;

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    restart;
    bit                      literal;
    out_item_t               verdict;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{16'sd0,      1'b0, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0}},
    '{16'sd1,      1'b0, 1'b1, '{1'b1, 1'b0, 12'd1, 12'd0}},
    '{16'sh8000,   1'b0, 1'b1, '{1'b1, 1'b0, 12'd1, 12'd0}},
    '{16'sh7FFF,   1'b1, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0}},
    '{16'sh8000,   1'b0, 1'b1, '{1'b1, 1'b1, 12'd1, 12'd0}},
    '{-16'sd1,     1'b1, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0}},
    '{-16'sd1,     1'b0, 1'b1, '{1'b1, 1'b1, 12'd1, 12'd0}},
    '{16'sh7FFF,   1'b0, 1'b1, '{1'b1, 1'b1, 12'd1, 12'd0}},
    '{16'sd100,    1'b1, 1'b0, '0},
    '{16'sd100,    1'b0, 1'b0, '0},
    '{16'sd0,      1'b1, 1'b0, '0},
    '{16'sd0,      1'b0, 1'b0, '0},
    '{16'sd0,      1'b0, 1'b0, '0},
    '{-16'sd5,     1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  tscd_stream_if #(.T(in_item_t))  in_chan ();
  tscd_stream_if #(.T(out_item_t)) out_chan ();
  tscd_stream_if #(.T(cfg_item_t)) cfg_chan ();

  two_sided_cusum_detector_unit #(
    .MAX_SAMPLES(SERIES_CAP)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_chan),
    .out_ch (out_chan),
    .cfg_ch (cfg_chan)
  );

  always #2 clk = ~clk;

  // model of the detector
  logic signed [SMP_W-1:0] mean_q;
  logic [MAG_W-1:0]        mag_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [THR_W-1:0]        thr_q;
  longint                  up_sum, down_sum, up_floor, down_floor;
  int                      up_at, down_at, next_index;
  out_item_t               held_verdict;

  out_item_t predicted_verdicts [$];
  int        samples_sent;
  int        verdicts_seen;
  int        fail_count;
  int        cycle_count;

  bit        gaps_on;
  int        stall_left;
  int        stim_mean;
  int        stim_mag;
  bit        row_literal;
  out_item_t row_verdict;

  function automatic longint clamp48(longint v);
    if (v > longint'(SUM_MAX)) return longint'(SUM_MAX);
    if (v < longint'(SUM_MIN)) return longint'(SUM_MIN);
    return v;
  endfunction

  function automatic void clear_series();
    up_sum = 0;
    down_sum = 0;
    up_floor = 0;
    down_floor = 0;
    up_at = 0;
    down_at = 0;
    next_index = 0;
    held_verdict = '0;
  endfunction

  function automatic out_item_t cusum_result(in_item_t it);
    longint d2, step_up, step_down;
    if (it.restart) clear_series();
    if (!held_verdict.alarm) begin
      d2 = 2 * (longint'(it.sample) - longint'(mean_q));
      step_up   = (longint'(gain_q) * (d2 - longint'(mag_q))) >>> 1;
      step_down = (longint'(gain_q) * (-d2 - longint'(mag_q))) >>> 1;
      up_sum   = clamp48(up_sum + step_up);
      down_sum = clamp48(down_sum + step_down);
      if (next_index == 0 || up_sum < up_floor) begin
        up_floor = up_sum;
        up_at = next_index;
      end
      if (next_index == 0 || down_sum < down_floor) begin
        down_floor = down_sum;
        down_at = next_index;
      end
      if (up_sum - up_floor > longint'(thr_q)) begin
        held_verdict = '{1'b1, 1'b0, OUT_IDX_W'(next_index), OUT_IDX_W'(up_at)};
      end else if (down_sum - down_floor > longint'(thr_q)) begin
        held_verdict = '{1'b1, 1'b1, OUT_IDX_W'(next_index), OUT_IDX_W'(down_at)};
      end
      if (!held_verdict.alarm && next_index < SERIES_CAP - 1) next_index++;
    end
    return held_verdict;
  endfunction

  function automatic void check_field(string tag, logic [OUT_IDX_W-1:0] want_v,
                                      logic [OUT_IDX_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, tag, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mean_q = '0;
      mag_q  = '0;
      gain_q = GAIN_RESET;
      thr_q  = '0;
      clear_series();
      predicted_verdicts.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.payload.reg_index)
          REG_MEAN_LEVEL:       mean_q = cfg_chan.payload.wr_data[SMP_W-1:0];
          REG_CHANGE_MAGNITUDE: mag_q  = cfg_chan.payload.wr_data[MAG_W-1:0];
          REG_GAIN:             gain_q = cfg_chan.payload.wr_data[GAIN_W-1:0];
          REG_THRESHOLD:        thr_q  = cfg_chan.payload.wr_data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        want = cusum_result(in_chan.payload);
        predicted_verdicts.push_back(row_literal ? row_verdict : want);
      end
      if (out_chan.valid && out_chan.ready) begin
        verdicts_seen++;
        if (predicted_verdicts.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %p",
                   $time, out_chan.payload);
          fail_count++;
        end else begin
          want = predicted_verdicts.pop_front();
          check_field("alarm", OUT_IDX_W'(want.alarm),
                      OUT_IDX_W'(out_chan.payload.alarm));
          check_field("direction", OUT_IDX_W'(want.direction),
                      OUT_IDX_W'(out_chan.payload.direction));
          check_field("detect_index", want.detect_index, out_chan.payload.detect_index);
          check_field("change_index", want.change_index, out_chan.payload.change_index);
        end
      end
    end
  end

  // result-side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [SMP_W-1:0] sample, input logic restart,
                             input bit literal, input out_item_t verdict);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= '{sample, restart};
    row_literal     <= literal;
    row_verdict     <= verdict;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_seen != samples_sent) @(posedge clk);
  endtask

  task automatic write_regs(input int mean, input int mag, input int gain,
                            input logic [THR_W-1:0] thr);
    cfg_item_t writes [4];
    writes[0] = '{REG_MEAN_LEVEL, THR_W'(mean)};
    writes[1] = '{REG_CHANGE_MAGNITUDE, THR_W'(mag)};
    writes[2] = '{REG_GAIN, THR_W'(gain)};
    writes[3] = '{REG_THRESHOLD, thr};
    stim_mean = mean;
    stim_mag  = mag;
    wait_drained();
    foreach (writes[w]) begin
      cfg_chan.valid   <= 1'b1;
      cfg_chan.payload <= writes[w];
      @(posedge clk);
      while (!cfg_chan.ready) @(posedge clk);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic random_regs();
    int gain, mag;
    longint thr;
    mag  = $urandom_range(1, 4000);
    gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 65535);
    if ($urandom_range(0, 3) == 0) begin
      thr = longint'({$urandom, $urandom}) & longint'(THR_ALL);
    end else begin
      thr = (longint'(gain) * mag / 2) * $urandom_range(1, 12);
    end
    write_regs(int'($urandom_range(0, 32767)) - 16384, mag, gain, THR_W'(thr));
  endtask

  function automatic logic signed [SMP_W-1:0] near_level(int centre, int spread);
    int v;
    v = int'($urandom_range(0, 2 * spread)) - spread + centre;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SMP_W'(v);
  endfunction

  // mostly clean series: baseline, then a shifted segment; some raw noise
  task automatic run_traffic(input int n_items);
    int sent, spread, shift, base_len, shift_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        push_sample(SMP_W'($urandom), $urandom_range(0, 9) == 0, 1'b0, '0);
        sent++;
      end else begin
        spread    = stim_mag / 4 + 1;
        shift     = stim_mag + $urandom_range(0, stim_mag);
        base_len  = $urandom_range(1, 40);
        shift_len = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) shift = -shift;
        for (int k = 0; k < base_len; k++) begin
          push_sample(near_level(stim_mean, spread), k == 0, 1'b0, '0);
        end
        for (int k = 0; k < shift_len; k++) begin
          push_sample(near_level(stim_mean + shift, spread), 1'b0, 1'b0, '0);
        end
        sent += base_len + shift_len;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.payload  = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.payload = '0;
    out_chan.ready   = 1'b0;
    row_literal      = 1'b0;
    row_verdict      = '0;
    gaps_on          = 1'b1;
    stim_mean        = 0;
    stim_mag         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      push_sample(directed_rows[r].sample, directed_rows[r].restart,
                  directed_rows[r].literal, directed_rows[r].verdict);
    end

    write_regs(-32768, 65535, 65535, THR_ALL);
    run_traffic(30);
    write_regs(32767, 0, 0, '0);
    run_traffic(30);
    write_regs(0, 65535, 1, 40'd1);
    run_traffic(30);
    write_regs(-32768, 0, 65535, '0);
    run_traffic(30);
    write_regs(32767, 65535, 65535, THR_ALL);
    run_traffic(30);

    repeat (10) begin
      gaps_on = $urandom_range(0, 3) != 0;
      random_regs();
      run_traffic(70);
    end

    // drive the upward sum steeply downward, then push it back up
    gaps_on = 1'b1;
    write_regs(32767, 65535, 65535, THR_ALL);
    push_sample(SMP_W'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
    repeat (DRAIN_ITEMS) push_sample(SMP_W'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
    write_regs(0, 0, 256, 40'd1000);
    repeat (20) push_sample(SMP_W'($urandom_range(1000, 32767)), 1'b0, 1'b0, '0);

    random_regs();
    gaps_on = 1'b0;
    run_traffic(150);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && predicted_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
